// ===== design/trdor_pkg.sv =====
// Package for the torus dimension-order route walker
// Holds widths, register indexes, item structs, sequencer states and helpers
// No dependencies
`default_nettype none

package trdor_pkg;

  // geometry of the walk
  localparam int NUM_DIMS     = 5;
  localparam int MAX_DIM_SIZE = 16;
  localparam int LAST_DIM_CAP = 4;
  localparam int COORD_W      = $clog2(MAX_DIM_SIZE);
  localparam int SIZE_W       = COORD_W + 1;
  localparam int DIM_W        = 3;
  localparam int IDX_W        = 6;
  localparam int ORDER_W      = NUM_DIMS * DIM_W;
  localparam logic [IDX_W-1:0] MAX_HOPS = 6'd63;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_DIM0_SIZE  = 3'd0;
  localparam logic [2:0] REG_DIM1_SIZE  = 3'd1;
  localparam logic [2:0] REG_DIM2_SIZE  = 3'd2;
  localparam logic [2:0] REG_DIM3_SIZE  = 3'd3;
  localparam logic [2:0] REG_DIM4_SIZE  = 3'd4;
  localparam logic [2:0] REG_WRAP_MASK  = 3'd5;
  localparam logic [2:0] REG_WALK_ORDER = 3'd6;

  // register reset values
  localparam logic [4:0]         DIM_SIZE_RST   = 5'd4;
  localparam logic [2:0]         DIM4_SIZE_RST  = 3'd2;
  localparam logic [4:0]         WRAP_MASK_RST  = 5'd31;
  localparam logic [ORDER_W-1:0] WALK_ORDER_RST = 15'd18056;

  // request item: source and destination node
  typedef struct packed {
    logic [3:0] src_c0;
    logic [3:0] src_c1;
    logic [3:0] src_c2;
    logic [3:0] src_c3;
    logic [1:0] src_c4;
    logic [3:0] dst_c0;
    logic [3:0] dst_c1;
    logic [3:0] dst_c2;
    logic [3:0] dst_c3;
    logic [1:0] dst_c4;
  } route_req_t;

  // result item: one hop
  typedef struct packed {
    logic [3:0]       hop_c0;
    logic [3:0]       hop_c1;
    logic [3:0]       hop_c2;
    logic [3:0]       hop_c3;
    logic [1:0]       hop_c4;
    logic [IDX_W-1:0] hop_index;
    logic [DIM_W-1:0] hop_dim;
    logic             last_hop;
  } route_hop_t;

  // plan for one dimension
  typedef struct packed {
    logic [COORD_W-1:0] hops;
    logic               plus;
  } dim_plan_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIM   = 4'b0100,
    ST_STEP  = 4'b1000
  } seq_state_t;

  // clamp a size register into 1..cap
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r == '0) r = SIZE_W'(1);
    if (r > cap) r = cap;
    return r;
  endfunction

  // saturate a coordinate to size minus one
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] c,
                                                   input logic [SIZE_W-1:0]  size);
    logic [SIZE_W-1:0] lim;
    lim = size - SIZE_W'(1);
    return ({1'b0, c} >= size) ? lim[COORD_W-1:0] : c;
  endfunction

endpackage

`default_nettype wire

// ===== design/trdor_plan.sv =====
// Per-dimension planner: hop count and direction for one walk entry
// Depends on trdor_pkg
`default_nettype none

module trdor_plan
  import trdor_pkg::*;
(
  input  logic [COORD_W-1:0] src,
  input  logic [COORD_W-1:0] dst,
  input  logic [SIZE_W-1:0]  size,
  input  logic               torus,
  output dim_plan_t          plan
);

  logic [COORD_W-1:0] diff;
  logic [SIZE_W-1:0]  diff_w;
  logic [SIZE_W-1:0]  alt;
  logic [SIZE_W-1:0]  twice;

  // distance the straight way and the way around
  assign diff   = (dst >= src) ? (dst - src) : (src - dst);
  assign diff_w = {1'b0, diff};
  assign alt    = size - diff_w;
  assign twice  = {diff, 1'b0};

  // shorter way in a torus, half-way tie by source parity
  always_comb begin
    plan.hops = diff;
    plan.plus = (dst > src);
    if (torus) begin
      if (alt < diff_w) plan.hops = alt[COORD_W-1:0];
      if (twice > size)      plan.plus = (dst < src);
      else if (twice < size) plan.plus = (dst > src);
      else                   plan.plus = ~src[0];
    end
  end

endmodule

`default_nettype wire

// ===== design/trdor_step.sv =====
// Shared hop stepper: moves one coordinate by one node, wrapping in a torus
// Depends on trdor_pkg
`default_nettype none

module trdor_step
  import trdor_pkg::*;
(
  input  logic [COORD_W-1:0] pos,
  input  logic [SIZE_W-1:0]  size,
  input  logic               plus,
  input  logic               torus,
  output logic [COORD_W-1:0] pos_next
);

  logic [SIZE_W-1:0] inc;
  logic [SIZE_W-1:0] top;

  assign inc = {1'b0, pos} + SIZE_W'(1);
  assign top = size - SIZE_W'(1);

  // one step up or down, wrapping at the ends of a torus ring
  always_comb begin
    if (plus) begin
      if (torus && inc == size) pos_next = '0;
      else                      pos_next = inc[COORD_W-1:0];
    end else begin
      if (torus && pos == '0) pos_next = top[COORD_W-1:0];
      else                    pos_next = pos - COORD_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/torus_dimension_order_route.sv =====
// Sequence: accept, a setup state, then per walk entry a planning state and,
// for a walked dimension, a step state for each hop and then a closing step.
// One hop leaves per cycle while the output register is not stalled.
// Throughput: one item at a time; the next item is taken once the walk ends,
// while the last hop may still wait in the output register.
// Reset: rst is synchronous, active high; registers return to 4,4,4,4,2 / 31 / 18056.
`default_nettype none

module torus_dimension_order_route
  import trdor_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  route_req_t        req_data,
  // hop channel
  output logic              hop_valid,
  input  logic              hop_ready,
  output route_hop_t        hop_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [4:0]         dim0_size, dim1_size, dim2_size, dim3_size;
  logic [2:0]         dim4_size;
  logic [4:0]         wrap_mask;
  logic [ORDER_W-1:0] walk_order;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // sequencer and walk state
  seq_state_t         state, state_next;
  route_req_t         req_q;
  logic [COORD_W-1:0] src_s [NUM_DIMS];
  logic [COORD_W-1:0] dst_s [NUM_DIMS];
  logic [COORD_W-1:0] pos   [NUM_DIMS];
  logic [DIM_W-1:0]   order_step;
  logic [NUM_DIMS-1:0] used;
  logic [DIM_W-1:0]   cur_dim;
  logic               cur_plus;
  logic               cur_torus;
  logic [COORD_W-1:0] hops_left;
  logic [IDX_W-1:0]   hop_count;

  // derived signals
  logic [SIZE_W-1:0]  size  [NUM_DIMS];
  logic [COORD_W-1:0] src_raw [NUM_DIMS];
  logic [COORD_W-1:0] dst_raw [NUM_DIMS];
  logic [DIM_W-1:0]   entry_dim;
  logic               entry_ok;
  logic [DIM_W-1:0]   plan_dim;
  dim_plan_t          plan;
  logic [COORD_W-1:0] step_pos;
  logic [COORD_W-1:0] new_pos [NUM_DIMS];
  logic               at_dst;
  logic               emit;
  logic               step_done;
  logic               last_entry;

  // apb write decode and read mux
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      REG_DIM0_SIZE:  prdata = DATA_W'(dim0_size);
      REG_DIM1_SIZE:  prdata = DATA_W'(dim1_size);
      REG_DIM2_SIZE:  prdata = DATA_W'(dim2_size);
      REG_DIM3_SIZE:  prdata = DATA_W'(dim3_size);
      REG_DIM4_SIZE:  prdata = DATA_W'(dim4_size);
      REG_WRAP_MASK:  prdata = DATA_W'(wrap_mask);
      REG_WALK_ORDER: prdata = DATA_W'(walk_order);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim0_size  <= DIM_SIZE_RST;
      dim1_size  <= DIM_SIZE_RST;
      dim2_size  <= DIM_SIZE_RST;
      dim3_size  <= DIM_SIZE_RST;
      dim4_size  <= DIM4_SIZE_RST;
      wrap_mask  <= WRAP_MASK_RST;
      walk_order <= WALK_ORDER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DIM0_SIZE:  dim0_size  <= pwdata[4:0];
        REG_DIM1_SIZE:  dim1_size  <= pwdata[4:0];
        REG_DIM2_SIZE:  dim2_size  <= pwdata[4:0];
        REG_DIM3_SIZE:  dim3_size  <= pwdata[4:0];
        REG_DIM4_SIZE:  dim4_size  <= pwdata[2:0];
        REG_WRAP_MASK:  wrap_mask  <= pwdata[4:0];
        REG_WALK_ORDER: walk_order <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  assign size[0] = eff_size(dim0_size, SIZE_W'(MAX_DIM_SIZE));
  assign size[1] = eff_size(dim1_size, SIZE_W'(MAX_DIM_SIZE));
  assign size[2] = eff_size(dim2_size, SIZE_W'(MAX_DIM_SIZE));
  assign size[3] = eff_size(dim3_size, SIZE_W'(MAX_DIM_SIZE));
  assign size[4] = eff_size({2'b00, dim4_size}, SIZE_W'(LAST_DIM_CAP));

  // unpack the held request
  assign src_raw[0] = req_q.src_c0;
  assign src_raw[1] = req_q.src_c1;
  assign src_raw[2] = req_q.src_c2;
  assign src_raw[3] = req_q.src_c3;
  assign src_raw[4] = {2'b00, req_q.src_c4};
  assign dst_raw[0] = req_q.dst_c0;
  assign dst_raw[1] = req_q.dst_c1;
  assign dst_raw[2] = req_q.dst_c2;
  assign dst_raw[3] = req_q.dst_c3;
  assign dst_raw[4] = {2'b00, req_q.dst_c4};

  // current walk entry; unknown or repeated dimensions are skipped
  assign entry_dim  = walk_order[DIM_W*order_step +: DIM_W];
  assign entry_ok   = (entry_dim < DIM_W'(NUM_DIMS)) && !used[entry_dim];
  assign plan_dim   = entry_ok ? entry_dim : '0;
  assign last_entry = (order_step == DIM_W'(NUM_DIMS - 1));

  trdor_plan u_plan (
    .src   (src_s[plan_dim]),
    .dst   (dst_s[plan_dim]),
    .size  (size[plan_dim]),
    .torus (wrap_mask[plan_dim]),
    .plan  (plan)
  );

  trdor_step u_step (
    .pos      (pos[cur_dim]),
    .size     (size[cur_dim]),
    .plus     (cur_plus),
    .torus    (cur_torus),
    .pos_next (step_pos)
  );

  // position after this hop and destination check
  always_comb begin
    at_dst = 1'b1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      new_pos[d] = (cur_dim == DIM_W'(d)) ? step_pos : pos[d];
      if (new_pos[d] != dst_s[d]) at_dst = 1'b0;
    end
  end

  assign step_done = (hops_left == '0) || (hop_count == MAX_HOPS);
  assign emit      = (state == ST_STEP) && !step_done && (!hop_valid || hop_ready);
  assign req_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_DIM;
      ST_DIM: begin
        if (entry_ok)        state_next = ST_STEP;
        else if (last_entry) state_next = ST_IDLE;
      end
      ST_STEP: begin
        if (step_done) state_next = last_entry ? ST_IDLE : ST_DIM;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      order_step <= '0;
      used       <= '0;
      hops_left  <= '0;
      hop_count  <= '0;
      cur_dim    <= '0;
      cur_plus   <= 1'b0;
      cur_torus  <= 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) pos[d] <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (req_valid) req_q <= req_data;
        end
        ST_SETUP: begin
          for (int d = 0; d < NUM_DIMS; d++) begin
            src_s[d] <= sat_coord(src_raw[d], size[d]);
            dst_s[d] <= sat_coord(dst_raw[d], size[d]);
            pos[d]   <= sat_coord(src_raw[d], size[d]);
          end
          order_step <= '0;
          used       <= '0;
          hop_count  <= '0;
          hops_left  <= '0;
        end
        ST_DIM: begin
          if (entry_ok) begin
            used[plan_dim] <= 1'b1;
            cur_dim        <= plan_dim;
            cur_plus       <= plan.plus;
            cur_torus      <= wrap_mask[plan_dim];
            hops_left      <= plan.hops;
          end else if (!last_entry) begin
            order_step <= order_step + DIM_W'(1);
          end
        end
        ST_STEP: begin
          if (emit) begin
            pos[cur_dim] <= step_pos;
            hops_left    <= hops_left - COORD_W'(1);
            hop_count    <= hop_count + IDX_W'(1);
          end else if (step_done) begin
            hops_left <= '0;
            if (!last_entry) order_step <= order_step + DIM_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hop_valid <= 1'b0;
    end else if (emit) begin
      hop_valid <= 1'b1;
    end else if (hop_ready) begin
      hop_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hop_data.hop_c0    <= new_pos[0];
      hop_data.hop_c1    <= new_pos[1];
      hop_data.hop_c2    <= new_pos[2];
      hop_data.hop_c3    <= new_pos[3];
      hop_data.hop_c4    <= new_pos[4][1:0];
      hop_data.hop_index <= hop_count + IDX_W'(1);
      hop_data.hop_dim   <= cur_dim;
      hop_data.last_hop  <= at_dst;
    end
  end

endmodule

`default_nettype wire

// ===== design/trdor_check.sv =====
// Port-level checker for the route walker, bound to the top level
// Depends on trdor_pkg and torus_dimension_order_route
`default_nettype none

module trdor_check
  import trdor_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       hop_valid,
  input logic       hop_ready,
  input route_hop_t hop_data
);

  // a stalled hop item holds
  a_hop_hold: assert property (@(posedge clk) disable iff (rst)
    hop_valid && !hop_ready |=> hop_valid && $stable(hop_data))
    else $error("hop item changed while stalled");

  // block is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while walk in progress");

  // hop numbers are nonzero and dimensions are in range
  a_hop_fields: assert property (@(posedge clk) disable iff (rst)
    hop_valid |-> hop_data.hop_index != '0 && hop_data.hop_dim < DIM_W'(NUM_DIMS))
    else $error("hop index or dimension out of range");

  // after the hop that reaches the destination only a new route's first hop may follow
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    hop_valid && hop_ready && hop_data.last_hop |=>
      !hop_valid || hop_data.hop_index == IDX_W'(1))
    else $error("hop emitted after destination reached");

endmodule

bind torus_dimension_order_route trdor_check u_trdor_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .hop_valid (hop_valid),
  .hop_ready (hop_ready),
  .hop_data  (hop_data)
);

`default_nettype wire

// ===== verif/tb_torus_dimension_order_route.sv =====
// Testbench for torus_dimension_order_route: directed and random routes through several
// geometry settings, each hop checked against a walk predicted in the bench
// Depends on trdor_pkg and the torus_dimension_order_route RTL
`timescale 1ns / 1ps

module tb_torus_dimension_order_route;
  import trdor_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 36;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  route_req_t        req_data  = '0;
  logic              hop_valid;
  logic              hop_ready = 1'b0;
  route_hop_t        hop_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // geometry as the block should hold it
  logic [4:0]         size_cfg [NUM_DIMS];
  logic [4:0]         wrap_cfg;
  logic [ORDER_W-1:0] order_cfg;

  route_req_t route_backlog [$];
  route_hop_t expected_hops [$];
  int         mismatch_count = 0;
  int         send_idle_pct  = IDLE_PCT;
  int         recv_idle_pct  = IDLE_PCT;
  int         hold_requests  = 0;
  int         holds_started  = 0;
  int         hold_left      = 0;

  torus_dimension_order_route u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .hop_valid (hop_valid),
    .hop_ready (hop_ready),
    .hop_data  (hop_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // size register clamped into 1..cap
  function automatic int eff_span(input int d);
    int cap;
    int v;
    cap = (d == NUM_DIMS - 1) ? LAST_DIM_CAP : MAX_DIM_SIZE;
    v = size_cfg[d];
    if (v < 1) v = 1;
    if (v > cap) v = cap;
    return v;
  endfunction

  // walk one route in dimension order and queue every hop it makes
  function automatic void walk_route(input route_req_t req);
    int span [NUM_DIMS];
    int src_pos [NUM_DIMS];
    int dst_pos [NUM_DIMS];
    int cur [NUM_DIMS];
    int d, k, n, diff, steps, count;
    logic [NUM_DIMS-1:0] walked;
    logic plus, torus, at_dst;
    route_hop_t hop;
    src_pos = '{req.src_c0, req.src_c1, req.src_c2, req.src_c3, req.src_c4};
    dst_pos = '{req.dst_c0, req.dst_c1, req.dst_c2, req.dst_c3, req.dst_c4};
    for (d = 0; d < NUM_DIMS; d++) begin
      span[d] = eff_span(d);
      if (src_pos[d] >= span[d]) src_pos[d] = span[d] - 1;
      if (dst_pos[d] >= span[d]) dst_pos[d] = span[d] - 1;
      cur[d] = src_pos[d];
    end
    walked = '0;
    count = 0;
    for (k = 0; k < NUM_DIMS; k++) begin
      d = order_cfg[DIM_W*k +: DIM_W];
      // entries naming no dimension or a repeated one are skipped
      if (d >= NUM_DIMS || walked[d]) continue;
      walked[d] = 1'b1;
      diff = (dst_pos[d] >= src_pos[d]) ? dst_pos[d] - src_pos[d] : src_pos[d] - dst_pos[d];
      torus = wrap_cfg[d];
      steps = diff;
      if (torus) begin
        if (span[d] - diff < steps) steps = span[d] - diff;
        if (2 * diff > span[d]) plus = dst_pos[d] < src_pos[d];
        else if (2 * diff < span[d]) plus = dst_pos[d] > src_pos[d];
        else plus = (src_pos[d] % 2) == 0;
      end else begin
        plus = dst_pos[d] > src_pos[d];
      end
      while (steps > 0 && count < MAX_HOPS) begin
        if (torus) cur[d] = plus ? (cur[d] + 1) % span[d] : (cur[d] + span[d] - 1) % span[d];
        else cur[d] = plus ? cur[d] + 1 : cur[d] - 1;
        steps--;
        count++;
        at_dst = 1'b1;
        for (n = 0; n < NUM_DIMS; n++) begin
          if (cur[n] != dst_pos[n]) at_dst = 1'b0;
        end
        hop.hop_c0    = 4'(cur[0]);
        hop.hop_c1    = 4'(cur[1]);
        hop.hop_c2    = 4'(cur[2]);
        hop.hop_c3    = 4'(cur[3]);
        hop.hop_c4    = 2'(cur[4]);
        hop.hop_index = IDX_W'(count);
        hop.hop_dim   = DIM_W'(d);
        hop.last_hop  = at_dst;
        expected_hops.push_back(hop);
      end
    end
  endfunction

  function automatic string hop_text(input route_hop_t h);
    return $sformatf("node=%0d/%0d/%0d/%0d/%0d idx=%0d dim=%0d last=%0b",
                     h.hop_c0, h.hop_c1, h.hop_c2, h.hop_c3, h.hop_c4,
                     h.hop_index, h.hop_dim, h.last_hop);
  endfunction

  // mostly in-range endpoints, some equal pairs, the rest raw bits
  function automatic route_req_t random_route();
    route_req_t r;
    logic [63:0] bits;
    int pick;
    bits = {$urandom(), $urandom()};
    r = bits[$bits(route_req_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 85) begin
      r.src_c0 = 4'($urandom_range(eff_span(0) - 1));
      r.src_c1 = 4'($urandom_range(eff_span(1) - 1));
      r.src_c2 = 4'($urandom_range(eff_span(2) - 1));
      r.src_c3 = 4'($urandom_range(eff_span(3) - 1));
      r.src_c4 = 2'($urandom_range(eff_span(4) - 1));
      r.dst_c0 = 4'($urandom_range(eff_span(0) - 1));
      r.dst_c1 = 4'($urandom_range(eff_span(1) - 1));
      r.dst_c2 = 4'($urandom_range(eff_span(2) - 1));
      r.dst_c3 = 4'($urandom_range(eff_span(3) - 1));
      r.dst_c4 = 2'($urandom_range(eff_span(4) - 1));
    end
    if (pick >= 75 && pick < 85) begin
      {r.dst_c0, r.dst_c1, r.dst_c2, r.dst_c3, r.dst_c4} =
        {r.src_c0, r.src_c1, r.src_c2, r.src_c3, r.src_c4};
    end
    return r;
  endfunction

  // mostly a shuffled permutation, sometimes raw bits
  function automatic logic [ORDER_W-1:0] random_walk_order();
    int perm [NUM_DIMS];
    int i, j, t;
    logic [ORDER_W-1:0] v;
    if ($urandom_range(99) < 20) return ORDER_W'($urandom_range(32767));
    for (i = 0; i < NUM_DIMS; i++) perm[i] = i;
    for (i = NUM_DIMS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < NUM_DIMS; i++) v[DIM_W*i +: DIM_W] = DIM_W'(perm[i]);
    return v;
  endfunction

  function automatic void queue_route(input int s0, s1, s2, s3, s4, d0, d1, d2, d3, d4);
    route_req_t r;
    r.src_c0 = 4'(s0);
    r.src_c1 = 4'(s1);
    r.src_c2 = 4'(s2);
    r.src_c3 = 4'(s3);
    r.src_c4 = 2'(s4);
    r.dst_c0 = 4'(d0);
    r.dst_c1 = 4'(d1);
    r.dst_c2 = 4'(d2);
    r.dst_c3 = 4'(d3);
    r.dst_c4 = 2'(d4);
    route_backlog.push_back(r);
  endfunction

  function automatic void queue_random(input int count);
    repeat (count) route_backlog.push_back(random_route());
  endfunction

  // setup phase, then access phase until pready
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WRAP_MASK:  wrap_cfg = value[4:0];
      REG_WALK_ORDER: order_cfg = value[ORDER_W-1:0];
      REG_DIM4_SIZE:  size_cfg[4] = {2'b00, value[2:0]};
      default:        size_cfg[idx] = value[4:0];
    endcase
  endtask

  task automatic set_geometry(input int s0, s1, s2, s3, s4, wrap, order);
    write_reg(REG_DIM0_SIZE, DATA_W'(s0));
    write_reg(REG_DIM1_SIZE, DATA_W'(s1));
    write_reg(REG_DIM2_SIZE, DATA_W'(s2));
    write_reg(REG_DIM3_SIZE, DATA_W'(s3));
    write_reg(REG_DIM4_SIZE, DATA_W'(s4));
    write_reg(REG_WRAP_MASK, DATA_W'(wrap));
    write_reg(REG_WALK_ORDER, DATA_W'(order));
  endtask

  // all items taken, all hops seen, then room for a walk that makes no hop
  task automatic wait_drained();
    while (route_backlog.size() > 0 || req_valid || expected_hops.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) walk_route(req_data);
      if (!req_valid || req_ready) begin
        if (route_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req_data  <= route_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // hop monitor and receiver backpressure
  always @(posedge clk) begin
    route_hop_t want;
    logic bad;
    if (rst) begin
      hop_ready <= 1'b0;
    end else begin
      if (hop_valid && hop_ready) begin
        if (expected_hops.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected hop, expected none, actual %s", $time, hop_text(hop_data));
        end else begin
          want = expected_hops.pop_front();
          bad = (hop_data.hop_c0 !== want.hop_c0) || (hop_data.hop_c1 !== want.hop_c1) ||
                (hop_data.hop_c2 !== want.hop_c2) || (hop_data.hop_c3 !== want.hop_c3) ||
                (hop_data.hop_c4 !== want.hop_c4) || (hop_data.hop_index !== want.hop_index) ||
                (hop_data.hop_dim !== want.hop_dim) || (hop_data.last_hop !== want.last_hop);
          if (bad) begin
            mismatch_count++;
            $display("%0t: hop mismatch, expected %s, actual %s",
                     $time, hop_text(want), hop_text(hop_data));
          end
        end
      end
      // long hold-off so the block fills and stalls its input
      if (hold_left > 0) begin
        hop_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (holds_started != hold_requests) begin
        holds_started <= holds_started + 1;
        hold_left     <= HOLD_CYCLES;
        hop_ready     <= 1'b0;
      end else begin
        hop_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    size_cfg  = '{5'd4, 5'd4, 5'd4, 5'd4, 5'd2};
    wrap_cfg  = 5'd31;
    order_cfg = 15'd18056;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: 4x4x4x4x2 torus, natural order
    queue_route(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);        // equal endpoints
    queue_route(0, 1, 0, 0, 0, 2, 1, 0, 0, 0);        // half-way tie from even source
    queue_route(1, 3, 0, 0, 0, 3, 1, 0, 0, 0);        // half-way tie from odd source
    queue_route(0, 0, 0, 0, 0, 3, 3, 3, 3, 1);        // short way round
    queue_route(15, 15, 15, 15, 3, 0, 0, 0, 0, 0);    // source saturates
    queue_route(2, 1, 0, 3, 1, 15, 15, 15, 15, 3);    // destination saturates
    queue_random(20);
    wait_drained();

    // full size mesh, longest possible route both ways
    set_geometry(16, 16, 16, 16, 4, 0, 18056);
    queue_route(0, 0, 0, 0, 0, 15, 15, 15, 15, 3);
    queue_route(15, 15, 15, 15, 3, 0, 0, 0, 0, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(30);
    wait_drained();

    // receiver stalls while routes keep coming
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    hold_requests++;
    queue_random(20);
    wait_drained();

    // zero and oversize sizes, torus, order with bad and repeated entries
    set_geometry(0, 31, 17, 1, 7, 31, 7 | (2 << 3) | (2 << 6) | (5 << 9) | (4 << 12));
    queue_route(5, 5, 5, 5, 3, 9, 9, 9, 9, 0);
    queue_route(0, 0, 3, 0, 0, 0, 0, 11, 0, 0);       // tie on size 16, odd source
    queue_route(0, 0, 4, 0, 0, 0, 0, 12, 0, 0);       // tie on size 16, even source
    queue_random(20);
    wait_drained();

    // small mixed geometry, order starting with an unused code
    set_geometry(2, 3, 5, 8, 3, 10, 6 | (0 << 3) | (1 << 6) | (3 << 9) | (2 << 12));
    queue_random(20);
    wait_drained();

    // random geometries
    repeat (3) begin
      set_geometry($urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
                   $urandom_range(0, 20), $urandom_range(0, 7), $urandom_range(31),
                   random_walk_order());
      queue_random(10);
      wait_drained();
    end

    // order naming no dimension at all: no hops
    set_geometry(16, 16, 16, 16, 4, 31, 32767);
    queue_route(0, 0, 0, 0, 0, 15, 15, 15, 15, 3);
    queue_route(3, 7, 1, 9, 2, 8, 0, 14, 2, 0);
    wait_drained();

    // order walking only dimension zero
    write_reg(REG_WALK_ORDER, DATA_W'(0));
    queue_route(1, 2, 3, 4, 1, 9, 2, 3, 4, 1);
    queue_route(1, 2, 3, 4, 1, 9, 5, 6, 7, 2);
    queue_random(5);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
